/* sv/tssb_pkg.sv */
// shared types and constants for the text screen shadow buffer
package tssb_pkg;
    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] ATTR_RESET = 8'd7;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    typedef enum logic [2:0] {
        ACT_PUT    = 3'd0,
        ACT_ATTR   = 3'd1,
        ACT_CURSOR = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_SCROLL = 3'd4,
        ACT_RESET  = 3'd5,
        ACT_CRC    = 3'd6,
        ACT_NONE   = 3'd7
    } action_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  char_code;
        logic [7:0]  attribute;
        logic [7:0]  target_row;
        logic [7:0]  target_col;
        logic        clear_line;
        logic [8:0]  scroll_amount;
    } cmd_t;

    typedef struct packed {
        logic [31:0] checksum;
        logic [7:0]  cursor_row;
        logic [7:0]  cursor_col;
    } rsp_t;

    // one crc step over a byte, eight shifts on a 32-bit value
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int j = 0; j < 8; j++)
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        return c;
    endfunction
endpackage

/* sv/tssb_if.sv */
// valid/ready channel interfaces
interface tssb_cmd_if (input logic clk);
    logic valid;
    logic ready;
    tssb_pkg::cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tssb_rsp_if (input logic clk);
    logic valid;
    logic ready;
    tssb_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tssb_cfg_if (input logic clk);
    logic valid;
    logic ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/tssb_mem.sv */
// cell memory, one write port and one registered read port
module tssb_mem #(
    parameter int DEPTH = tssb_pkg::ROWS_DEF * tssb_pkg::COLS_DEF,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);
    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

/* sv/text_screen_shadow_buffer_top.sv */
// text screen shadow buffer top level with sequencer, cursor and crc
// Each transfer on cmd yields one transfer on rsp. Put char, set attribute, set cursor and
// the unused action go straight to the response; a line feed or wrap at the bottom row adds a scroll by one.
// Clear line walks one row. Clear screen and reset walk all ROWS*COLS
// cells, one a cycle. Scroll by n below ROWS copies (ROWS-n)*COLS cells, each read then written through
// the registered-read cell memory, then blanks n*COLS cells. Checksum reads every cell, one a
// cycle. After rst_n the block clears the memory (all ROWS*COLS cells) before it
// takes its first command. cfg writes are taken at any time.
module text_screen_shadow_buffer_top #(
    parameter int ROWS = tssb_pkg::ROWS_DEF,
    parameter int COLS = tssb_pkg::COLS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tssb_cmd_if.sink   cmd,
    tssb_rsp_if.source rsp,
    tssb_cfg_if.sink   cfg
);
    localparam int DEPTH = ROWS * COLS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [7:0] LAST_ROW = 8'(ROWS - 1);
    localparam logic [7:0] LAST_COL = 8'(COLS - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [AW-1:0] COLS_A = AW'(COLS);

    typedef enum logic [2:0] {
        S_IDLE, S_FILL, S_COPY_RD, S_COPY_WR, S_CRC, S_CRC_END, S_DONE
    } state_t;

    state_t state_reg;
    tssb_pkg::cmd_t cmd_reg;
    logic [7:0] row_reg, col_reg, attr_reg, dflt_reg;
    logic [AW-1:0] addr_reg, end_reg, src_reg, copy_end_reg, fill_lo_reg, fill_hi_reg;
    logic up_reg, home_reg, crc_valid_reg;
    logic init_reg;
    logic [31:0] crc_reg;
    logic rsp_valid_reg;
    tssb_pkg::rsp_t rsp_reg;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0] wdata, rdata;

    tssb_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign cfg.ready = 1'b1;
    assign cmd.ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data = rsp_reg;

    logic [AW-1:0] row_base;
    logic [15:0] prod;
    assign prod = 16'(row_reg) * 16'(COLS);
    assign row_base = AW'(prod);

    logic [15:0] blank;
    assign blank = {attr_reg, tssb_pkg::SPACE_CHAR};

    // memory port selection
    always_comb
    begin
        we = 1'b0;
        waddr = addr_reg;
        wdata = blank;
        raddr = addr_reg;
        unique case (state_reg)
            S_FILL:
            begin
                we = 1'b1;
            end
            S_COPY_RD:
            begin
                raddr = src_reg;
            end
            S_COPY_WR:
            begin
                we = 1'b1;
                wdata = rdata;
            end
            S_IDLE:
            begin
                we = cmd.valid && cmd.ready
                    && tssb_pkg::action_t'(cmd.data.action) == tssb_pkg::ACT_PUT
                    && cmd.data.char_code != tssb_pkg::CHAR_CR
                    && cmd.data.char_code != tssb_pkg::CHAR_LF;
                waddr = AW'(row_base + AW'(col_reg));
                wdata = {attr_reg, cmd.data.char_code};
            end
            default:
            begin
            end
        endcase
    end

    // row count times COLS, for scroll distances
    function automatic int cnt_mul(input logic [7:0] n);
        return int'(n) * COLS;
    endfunction

    logic [8:0] amt_mag;
    logic amt_up;
    always_comb
    begin
        amt_up = !cmd_reg.scroll_amount[8];
        amt_mag = cmd_reg.scroll_amount[8] ? 9'(9'd0 - cmd_reg.scroll_amount)
                                           : cmd_reg.scroll_amount;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL;
            row_reg <= '0;
            col_reg <= '0;
            attr_reg <= tssb_pkg::ATTR_RESET;
            dflt_reg <= tssb_pkg::ATTR_RESET;
            addr_reg <= '0;
            end_reg <= LAST_ADDR;
            home_reg <= 1'b0;
            init_reg <= 1'b1;
            crc_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            up_reg <= 1'b1;
            src_reg <= '0;
            copy_end_reg <= '0;
            fill_lo_reg <= '0;
            fill_hi_reg <= '0;
            crc_reg <= '0;
            cmd_reg <= '0;
            rsp_reg <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                dflt_reg <= cfg.data;
            if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid && cmd.ready)
                    begin
                        cmd_reg <= cmd.data;
                        crc_valid_reg <= 1'b0;
                        unique case (tssb_pkg::action_t'(cmd.data.action))
                            tssb_pkg::ACT_PUT:
                            begin
                                if (cmd.data.char_code == tssb_pkg::CHAR_CR)
                                begin
                                    col_reg <= '0;
                                    state_reg <= S_DONE;
                                end
                                else if (cmd.data.char_code == tssb_pkg::CHAR_LF
                                         || col_reg == LAST_COL)
                                begin
                                    if (row_reg != LAST_ROW)
                                    begin
                                        if (cmd.data.char_code != tssb_pkg::CHAR_LF)
                                            col_reg <= '0;
                                        row_reg <= row_reg + 8'd1;
                                        state_reg <= S_DONE;
                                    end
                                    else if (ROWS == 1)
                                    begin
                                        col_reg <= '0;
                                        addr_reg <= '0;
                                        end_reg <= LAST_ADDR;
                                        state_reg <= S_FILL;
                                    end
                                    else
                                    begin
                                        // scroll up by one, row stays last
                                        if (cmd.data.char_code != tssb_pkg::CHAR_LF)
                                            col_reg <= '0;
                                        up_reg <= 1'b1;
                                        addr_reg <= '0;
                                        src_reg <= COLS_A;
                                        copy_end_reg <= AW'(DEPTH - COLS - 1);
                                        fill_lo_reg <= AW'(DEPTH - COLS);
                                        fill_hi_reg <= LAST_ADDR;
                                        state_reg <= S_COPY_RD;
                                    end
                                end
                                else
                                begin
                                    col_reg <= col_reg + 8'd1;
                                    state_reg <= S_DONE;
                                end
                            end
                            tssb_pkg::ACT_ATTR:
                            begin
                                attr_reg <= cmd.data.attribute;
                                state_reg <= S_DONE;
                            end
                            tssb_pkg::ACT_CURSOR:
                            begin
                                row_reg <= (cmd.data.target_row > LAST_ROW) ? LAST_ROW
                                                                            : cmd.data.target_row;
                                col_reg <= (cmd.data.target_col > LAST_COL) ? LAST_COL
                                                                            : cmd.data.target_col;
                                state_reg <= S_DONE;
                            end
                            tssb_pkg::ACT_CLEAR:
                            begin
                                if (cmd.data.clear_line)
                                begin
                                    addr_reg <= row_base;
                                    end_reg <= AW'(row_base + AW'(COLS - 1));
                                end
                                else
                                begin
                                    row_reg <= '0;
                                    col_reg <= '0;
                                    addr_reg <= '0;
                                    end_reg <= LAST_ADDR;
                                end
                                state_reg <= S_FILL;
                            end
                            tssb_pkg::ACT_SCROLL:
                            begin
                                if (cmd.data.scroll_amount != '0)
                                    home_reg <= 1'b1;
                                state_reg <= S_DONE;
                            end
                            tssb_pkg::ACT_RESET:
                            begin
                                attr_reg <= dflt_reg;
                                row_reg <= '0;
                                col_reg <= '0;
                                addr_reg <= '0;
                                end_reg <= LAST_ADDR;
                                state_reg <= S_FILL;
                            end
                            tssb_pkg::ACT_CRC:
                            begin
                                addr_reg <= '0;
                                crc_reg <= tssb_pkg::CRC_INIT;
                                state_reg <= S_CRC;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_FILL:
                begin
                    addr_reg <= addr_reg + AW'(1);
                    if (addr_reg == end_reg)
                    begin
                        init_reg <= 1'b0;
                        state_reg <= init_reg ? S_IDLE : S_DONE;
                    end
                end
                S_COPY_RD:
                begin
                    src_reg <= src_reg + AW'(1);
                    state_reg <= S_COPY_WR;
                end
                S_COPY_WR:
                begin
                    if (addr_reg == copy_end_reg)
                    begin
                        addr_reg <= fill_lo_reg;
                        end_reg <= fill_hi_reg;
                        state_reg <= S_FILL;
                    end
                    else
                    begin
                        addr_reg <= up_reg ? addr_reg + AW'(1) : addr_reg - AW'(1);
                        if (!up_reg)
                            src_reg <= src_reg - AW'(2);
                        state_reg <= S_COPY_RD;
                    end
                end
                S_CRC:
                begin
                    addr_reg <= addr_reg + AW'(1);
                    if (crc_valid_reg)
                        crc_reg <= tssb_pkg::crc_byte(tssb_pkg::crc_byte(crc_reg, rdata[7:0]),
                                                      rdata[15:8]);
                    crc_valid_reg <= 1'b1;
                    if (addr_reg == LAST_ADDR)
                        state_reg <= S_CRC_END;
                end
                S_CRC_END:
                begin
                    crc_reg <= tssb_pkg::crc_byte(tssb_pkg::crc_byte(crc_reg, rdata[7:0]),
                                                  rdata[15:8]);
                    crc_valid_reg <= 1'b0;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (home_reg)
                    begin
                        // scroll setup, in the cycle after accept
                        home_reg <= 1'b0;
                        if (amt_mag >= 9'(ROWS))
                        begin
                            row_reg <= '0;
                            col_reg <= '0;
                            addr_reg <= '0;
                            end_reg <= LAST_ADDR;
                            state_reg <= S_FILL;
                        end
                        else if (amt_up)
                        begin
                            up_reg <= 1'b1;
                            row_reg <= (row_reg >= amt_mag[7:0]) ? row_reg - amt_mag[7:0] : '0;
                            addr_reg <= '0;
                            src_reg <= AW'(cnt_mul(amt_mag[7:0]));
                            copy_end_reg <= AW'(DEPTH - 1 - cnt_mul(amt_mag[7:0]));
                            fill_lo_reg <= AW'(DEPTH - cnt_mul(amt_mag[7:0]));
                            fill_hi_reg <= LAST_ADDR;
                            state_reg <= S_COPY_RD;
                        end
                        else
                        begin
                            up_reg <= 1'b0;
                            row_reg <= (9'(row_reg) + amt_mag < 9'(ROWS))
                                       ? 8'(9'(row_reg) + amt_mag) : LAST_ROW;
                            addr_reg <= LAST_ADDR;
                            src_reg <= AW'(DEPTH - 1 - cnt_mul(amt_mag[7:0]));
                            copy_end_reg <= AW'(cnt_mul(amt_mag[7:0]));
                            fill_lo_reg <= '0;
                            fill_hi_reg <= AW'(cnt_mul(amt_mag[7:0]) - 1);
                            state_reg <= S_COPY_RD;
                        end
                    end
                    else if (!rsp_valid_reg)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_reg.checksum <=
                            (tssb_pkg::action_t'(cmd_reg.action) == tssb_pkg::ACT_CRC)
                            ? ~crc_reg : 32'd0;
                        rsp_reg.cursor_row <= row_reg;
                        rsp_reg.cursor_col <= col_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) row_reg <= LAST_ROW)
        else $error("cursor row out of range");
    assert property (@(posedge clk) disable iff (!rst_n) col_reg <= LAST_COL)
        else $error("cursor column out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("second command taken before response");
endmodule

/* tb/tssb_checker.sv */
// checker: watches command, response and config transfers and compares against a screen model
module tssb_checker #(
    parameter int ROWS = tssb_pkg::ROWS_DEF,
    parameter int COLS = tssb_pkg::COLS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    tssb_cmd_if.sink cmd,
    tssb_rsp_if.sink rsp,
    tssb_cfg_if.sink cfg,
    output int   errors,
    output int   pending,
    output int   n_rsp,
    output int   n_crc
);
    logic [15:0]      screen [ROWS*COLS];
    int               row_q;
    int               col_q;
    logic [7:0]       attr_q;
    logic [7:0]       dflt_attr;
    tssb_pkg::rsp_t   expected_rsp [$];

    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int j = 0; j < 8; j++)
            c = c[0] ? ((c >> 1) ^ tssb_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic blank_row(input int r);
        for (int c = 0; c < COLS; c++)
            screen[r*COLS + c] = {attr_q, tssb_pkg::SPACE_CHAR};
    endtask

    task automatic blank_screen();
        for (int r = 0; r < ROWS; r++)
            blank_row(r);
        row_q = 0;
        col_q = 0;
    endtask

    task automatic shift_rows_up(input int n);
        if (n >= ROWS)
            blank_screen();
        else
        begin
            for (int i = 0; i < (ROWS - n) * COLS; i++)
                screen[i] = screen[i + n*COLS];
            for (int r = ROWS - n; r < ROWS; r++)
                blank_row(r);
            row_q = (row_q >= n) ? row_q - n : 0;
        end
    endtask

    task automatic shift_rows_down(input int n);
        if (n >= ROWS)
            blank_screen();
        else
        begin
            for (int i = ROWS*COLS - 1; i >= n*COLS; i--)
                screen[i] = screen[i - n*COLS];
            for (int r = 0; r < n; r++)
                blank_row(r);
            row_q = (row_q + n < ROWS) ? row_q + n : ROWS - 1;
        end
    endtask

    task automatic line_feed();
        row_q++;
        if (row_q >= ROWS)
        begin
            shift_rows_up(1);
            row_q = ROWS - 1;
        end
    endtask

    task automatic apply_cmd(input tssb_pkg::cmd_t c);
        tssb_pkg::rsp_t r;
        logic [31:0]    crc;
        r.checksum = 32'd0;
        case (tssb_pkg::action_t'(c.action))
            tssb_pkg::ACT_PUT:
                if (c.char_code == tssb_pkg::CHAR_CR)
                    col_q = 0;
                else if (c.char_code == tssb_pkg::CHAR_LF)
                    line_feed();
                else
                begin
                    screen[row_q*COLS + col_q] = {attr_q, c.char_code};
                    col_q++;
                    if (col_q >= COLS)
                    begin
                        col_q = 0;
                        line_feed();
                    end
                end
            tssb_pkg::ACT_ATTR:
                attr_q = c.attribute;
            tssb_pkg::ACT_CURSOR:
            begin
                row_q = (c.target_row >= ROWS) ? ROWS - 1 : c.target_row;
                col_q = (c.target_col >= COLS) ? COLS - 1 : c.target_col;
            end
            tssb_pkg::ACT_CLEAR:
                if (c.clear_line)
                    blank_row(row_q);
                else
                    blank_screen();
            tssb_pkg::ACT_SCROLL:
                if (c.scroll_amount[8])
                    shift_rows_down(512 - int'(c.scroll_amount));
                else if (c.scroll_amount != 9'd0)
                    shift_rows_up(int'(c.scroll_amount));
            tssb_pkg::ACT_RESET:
            begin
                attr_q = dflt_attr;
                blank_screen();
            end
            tssb_pkg::ACT_CRC:
            begin
                crc = tssb_pkg::CRC_INIT;
                for (int i = 0; i < ROWS*COLS; i++)
                begin
                    crc = crc_step(crc, screen[i][7:0]);
                    crc = crc_step(crc, screen[i][15:8]);
                end
                r.checksum = crc ^ tssb_pkg::CRC_INIT;
            end
            default: ;
        endcase
        r.cursor_row = row_q[7:0];
        r.cursor_col = col_q[7:0];
        expected_rsp.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tssb_pkg::rsp_t e;
        if (!rst_n)
        begin
            dflt_attr = tssb_pkg::ATTR_RESET;
            attr_q = tssb_pkg::ATTR_RESET;
            blank_screen();
            expected_rsp.delete();
            pending = 0;
            errors <= 0;
            n_rsp <= 0;
            n_crc <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                n_rsp <= n_rsp + 1;
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t: unexpected response %h", $time, rsp.data);
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_rsp.pop_front();
                    if (e.checksum != 0)
                        n_crc <= n_crc + 1;
                    if (e.checksum !== rsp.data.checksum)
                    begin
                        $display("%0t: checksum expected %h actual %h", $time,
                                 e.checksum, rsp.data.checksum);
                        errors <= errors + 1;
                    end
                    if (e.cursor_row !== rsp.data.cursor_row
                        || e.cursor_col !== rsp.data.cursor_col)
                    begin
                        $display("%0t: cursor expected %0d,%0d actual %0d,%0d", $time,
                                 e.cursor_row, e.cursor_col,
                                 rsp.data.cursor_row, rsp.data.cursor_col);
                        errors <= errors + 1;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                apply_cmd(cmd.data);
            if (cfg.valid && cfg.ready)
                dflt_attr = cfg.data;
            pending = expected_rsp.size();
        end
    end
endmodule

/* tb/tb_top.sv */
// testbench top: stimulus, idling, config phases and verdict for the screen buffer
module tb_top;
    localparam int ROWS = tssb_pkg::ROWS_DEF;
    localparam int COLS = tssb_pkg::COLS_DEF;
    localparam int IDLE_LIMIT = 20 * ROWS * COLS + 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors;
    int   pending;
    int   n_rsp;
    int   n_crc;
    int   idle_cycles = 0;
    int   n_sent = 0;

    tssb_cmd_if cmd (clk);
    tssb_rsp_if rsp (clk);
    tssb_cfg_if cfg (clk);

    text_screen_shadow_buffer_top #(.ROWS(ROWS), .COLS(COLS)) DUT (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp), .cfg(cfg)
    );

    tssb_checker #(.ROWS(ROWS), .COLS(COLS)) u_checker (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp), .cfg(cfg),
        .errors(errors), .pending(pending), .n_rsp(n_rsp), .n_crc(n_crc)
    );

    always #5 clk = ~clk;

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // receiver stall pattern
    initial
    begin
        int g;
        rsp.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            rsp.ready <= 1'b1;
            g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
            @(posedge clk);
            if (g > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send(input tssb_pkg::cmd_t c, input bit no_gap);
        int g;
        cmd.data <= c;
        cmd.valid <= 1'b1;
        @(posedge clk iff cmd.ready);
        n_sent++;
        g = no_gap ? 0 : gap_len();
        if (g > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_attr(input logic [7:0] v);
        drain();
        cfg.data <= v;
        cfg.valid <= 1'b1;
        @(posedge clk iff cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    function automatic tssb_pkg::cmd_t mk(input tssb_pkg::action_t a);
        tssb_pkg::cmd_t c;
        logic [63:0]    r;
        r = {$urandom, $urandom};
        c = r[$bits(tssb_pkg::cmd_t)-1:0];
        c.action = a;
        return c;
    endfunction

    function automatic tssb_pkg::cmd_t rand_cmd();
        tssb_pkg::cmd_t c;
        int             p;
        p = $urandom_range(0, 99);
        if (p < 55)
        begin
            c = mk(tssb_pkg::ACT_PUT);
            p = $urandom_range(0, 19);
            if (p == 0)
                c.char_code = tssb_pkg::CHAR_CR;
            else if (p == 1)
                c.char_code = tssb_pkg::CHAR_LF;
            else if (p < 15)
                c.char_code = 8'($urandom_range(32, 126));
        end
        else if (p < 62)
            c = mk(tssb_pkg::ACT_ATTR);
        else if (p < 72)
        begin
            c = mk(tssb_pkg::ACT_CURSOR);
            if ($urandom_range(0, 3) != 0)
            begin
                c.target_row = 8'($urandom_range(0, ROWS + 1));
                c.target_col = 8'($urandom_range(0, COLS + 1));
            end
        end
        else if (p < 78)
        begin
            c = mk(tssb_pkg::ACT_CLEAR);
            if ($urandom_range(0, 3) != 0)
                c.clear_line = 1'b1;
        end
        else if (p < 88)
        begin
            c = mk(tssb_pkg::ACT_SCROLL);
            if ($urandom_range(0, 4) != 0)
                c.scroll_amount = 9'($signed($urandom_range(0, 2*ROWS + 2)) - ROWS - 1);
        end
        else if (p < 91)
            c = mk(tssb_pkg::ACT_RESET);
        else if (p < 98)
            c = mk(tssb_pkg::ACT_CRC);
        else
            c = mk(tssb_pkg::ACT_NONE);
        return c;
    endfunction

    initial
    begin
        tssb_pkg::cmd_t c;
        logic [7:0] attrs [4] = '{8'h00, 8'hFF, 8'h1E, 8'hA5};
        cmd.valid = 1'b0;
        cmd.data = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and each special case
        c = mk(tssb_pkg::ACT_CRC); send(c, 0);
        c = mk(tssb_pkg::ACT_PUT); c.char_code = 8'h00; send(c, 0);
        c = mk(tssb_pkg::ACT_PUT); c.char_code = 8'hFF; send(c, 0);
        c = mk(tssb_pkg::ACT_ATTR); c.attribute = 8'hFF; send(c, 0);
        c = mk(tssb_pkg::ACT_CURSOR); c.target_row = 8'hFF; c.target_col = 8'hFF; send(c, 0);
        c = mk(tssb_pkg::ACT_PUT); c.char_code = 8'h41; send(c, 0);
        c = mk(tssb_pkg::ACT_CRC); send(c, 0);
        c = mk(tssb_pkg::ACT_CURSOR); c.target_row = 8'(ROWS - 1); c.target_col = 8'd5;
        send(c, 0);
        c = mk(tssb_pkg::ACT_PUT); c.char_code = tssb_pkg::CHAR_LF; send(c, 0);
        c = mk(tssb_pkg::ACT_PUT); c.char_code = tssb_pkg::CHAR_CR; send(c, 0);
        c = mk(tssb_pkg::ACT_CURSOR); c.target_row = 8'd0; c.target_col = 8'd0; send(c, 0);
        c = mk(tssb_pkg::ACT_ATTR); c.attribute = 8'h00; send(c, 0);
        c = mk(tssb_pkg::ACT_SCROLL); c.scroll_amount = 9'd1; send(c, 0);
        c = mk(tssb_pkg::ACT_SCROLL); c.scroll_amount = -9'sd1; send(c, 0);
        c = mk(tssb_pkg::ACT_SCROLL); c.scroll_amount = 9'(ROWS - 1); send(c, 0);
        c = mk(tssb_pkg::ACT_SCROLL); c.scroll_amount = 9'd0; send(c, 0);
        c = mk(tssb_pkg::ACT_SCROLL); c.scroll_amount = 9'h101; send(c, 0);
        c = mk(tssb_pkg::ACT_CRC); send(c, 0);
        c = mk(tssb_pkg::ACT_SCROLL); c.scroll_amount = 9'd255; send(c, 0);
        c = mk(tssb_pkg::ACT_CLEAR); c.clear_line = 1'b1; send(c, 0);
        c = mk(tssb_pkg::ACT_CLEAR); c.clear_line = 1'b0; send(c, 0);
        c = mk(tssb_pkg::ACT_NONE); send(c, 0);
        c = mk(tssb_pkg::ACT_RESET); send(c, 0);
        c = mk(tssb_pkg::ACT_CRC); send(c, 0);

        // random phases, each with its own default attribute
        for (int ph = 0; ph < 4; ph++)
        begin
            write_attr(attrs[ph]);
            c = mk(tssb_pkg::ACT_RESET); send(c, 0);
            for (int i = 0; i < 380; i++)
            begin
                send(rand_cmd(), (i / 60) % 2 == 1);
                if (i == 190)
                    drain();
            end
            c = mk(tssb_pkg::ACT_CRC); send(c, 0);
        end

        drain();
        repeat (20) @(posedge clk);
        $display("sent %0d commands, checked %0d responses, %0d nonzero checksums",
                 n_sent, n_rsp, n_crc);
        $display("covered put/cr/lf/wrap, attributes, cursor clamp, clears, scrolls, resets");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
